[rtl/core/sorted_insert_list_defines.svh]
// assertion macros for the sorted insert list
`ifndef SORTED_INSERT_LIST_DEFINES_SVH
`define SORTED_INSERT_LIST_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SIL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SIL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sil_pkg.sv]
// shared types and constants for the sorted insert list
package sil_pkg;

  localparam int CAPACITY_DEFAULT = 32;
  localparam int KEY_W            = 32;
  localparam int HANDLE_W         = 16;
  localparam int POS_W            = 5;
  localparam int COUNT_W          = 6;
  localparam int CAP_CFG_W        = 6;
  localparam int CFG_DATA_W       = 6;
  localparam int CFG_IDX_W        = 1;
  localparam logic [CAP_CFG_W-1:0] CAP_RESET = 6'd32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DESC = 1'd0,
    CFG_CAP  = 1'd1
  } cfg_idx_t;

  // per-cell control driven from the top level
  typedef struct packed {
    logic desc;
    logic occupied;
    logic ins_en;
    logic rem_shift;
  } cell_ctl_t;

  // one result transaction
  typedef struct packed {
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  count;
    status_t             status;
  } res_t;

endpackage

[rtl/core/sil_cell.sv]
// one storage cell of the sorted chain: compare, hold, shift left or right
module sil_cell (
  input  logic                     clk,
  input  sil_pkg::cell_ctl_t       ctl,
  input  logic [sil_pkg::KEY_W-1:0]    new_key,
  input  logic [sil_pkg::HANDLE_W-1:0] new_handle,
  input  logic [sil_pkg::KEY_W-1:0]    left_key,
  input  logic [sil_pkg::HANDLE_W-1:0] left_handle,
  input  logic [sil_pkg::KEY_W-1:0]    right_key,
  input  logic [sil_pkg::HANDLE_W-1:0] right_handle,
  input  logic                     prefix_in,
  output logic                     prefix_out,
  output logic                     ins_here,
  output logic [sil_pkg::KEY_W-1:0]    key,
  output logic [sil_pkg::HANDLE_W-1:0] handle
);
  import sil_pkg::*;

  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic                earlier;

  // stored key strictly ahead of the new key in the current order
  assign earlier    = ctl.occupied & (ctl.desc ? (key_r > new_key) : (key_r < new_key));
  assign prefix_out = prefix_in & earlier;
  assign ins_here   = prefix_in & ~earlier;

  // take new entry, left neighbour on insert, right neighbour on remove
  always_comb begin
    key_nxt    = key_r;
    handle_nxt = handle_r;
    if (ctl.ins_en) begin
      if (ins_here) begin
        key_nxt    = new_key;
        handle_nxt = new_handle;
      end else if (!prefix_in) begin
        key_nxt    = left_key;
        handle_nxt = left_handle;
      end
    end else if (ctl.rem_shift) begin
      key_nxt    = right_key;
      handle_nxt = right_handle;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
  end

  assign key    = key_r;
  assign handle = handle_r;

endmodule

[rtl/core/sil_out_buf.sv]
// output register with skid stage for result transactions
module sil_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sil_pkg::res_t res_in,
  input  logic          out_stall,
  output logic          full,
  output logic          out_valid,
  output sil_pkg::res_t res_out
);
  import sil_pkg::*;

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic taken;

  assign taken = main_valid_r & ~out_stall;

  // refill the output register, park a result in the skid when held
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (push) begin
      if (!main_valid_r || taken) begin
        main_valid_nxt = 1'b1;
        main_nxt       = res_in;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res_in;
      end
    end else if (taken) begin
      main_valid_nxt = skid_valid_r;
      main_nxt       = skid_r;
      skid_valid_nxt = 1'b0;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign res_out   = main_r;

endmodule

[rtl/core/sorted_insert_list.sv]
// sorted insert list: the result of an accepted transaction is registered in the output buffer
// throughput: one transaction per cycle while the output side keeps up
// an add compares the new key in every cell at once; the ahead-of flag ripples
// along the cell chain to find the insert point, which sets the cycle length
// reset (synchronous, active low) clears the count, the config registers and
// the output valid flags; the cell storage is not cleared
module sorted_insert_list #(
  parameter int CAPACITY = sil_pkg::CAPACITY_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [sil_pkg::KEY_W-1:0]     in_key,
  input  logic [sil_pkg::HANDLE_W-1:0]  in_handle,
  input  logic [sil_pkg::POS_W-1:0]     in_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sil_pkg::POS_W-1:0]     out_position,
  output logic [sil_pkg::KEY_W-1:0]     out_key_out,
  output logic [sil_pkg::HANDLE_W-1:0]  out_handle_out,
  output logic [sil_pkg::COUNT_W-1:0]   out_count_out,
  output logic [1:0]                    out_status,
  input  logic                          cfg_we,
  input  logic [sil_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sil_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sil_pkg::*;

`include "sorted_insert_list_defines.svh"

  localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int XW = (IW > POS_W) ? IW : POS_W;

  logic                 desc_r;
  logic [CAP_CFG_W-1:0] cap_r;
  logic [CW-1:0]        count_r, count_nxt;

  logic                 accept, full_buf;
  cmd_t                 cmd;
  logic [LW-1:0]        limit, count_x;
  logic                 list_full, idx_ok, add_ok, get_ok, rem_ok;
  logic [XW-1:0]        idx_x;
  logic [IW-1:0]        rd_sel, ins_pos;
  logic [XW-1:0]        ins_pos_x;
  logic [LW-1:0]        count_nxt_x;
  res_t                 res, res_q;

  logic [KEY_W-1:0]     cell_key    [CAPACITY];
  logic [HANDLE_W-1:0]  cell_handle [CAPACITY];
  logic [CAPACITY:0]    prefix;
  logic [CAPACITY-1:0]  ins_here;
  cell_ctl_t            ctl [CAPACITY];

  assign accept   = in_valid & ~in_stall;
  assign in_stall = full_buf;
  assign cmd      = cmd_t'(in_cmd);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
      cap_r  <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DESC: desc_r <= cfg_wdata[0];
        CFG_CAP:  cap_r  <= cfg_wdata[CAP_CFG_W-1:0];
        default:  ;
      endcase
    end
  end

  // limit saturated at the cell count, range checks
  assign limit     = (LW'(cap_r) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(cap_r);
  assign count_x   = LW'(count_r);
  assign list_full = count_x >= limit;
  assign idx_x     = XW'(in_index);
  assign idx_ok    = LW'(in_index) < count_x;
  assign rd_sel    = idx_x[IW-1:0];
  assign add_ok    = accept & (cmd == CMD_ADD) & ~list_full;
  assign get_ok    = (cmd == CMD_GET) & idx_ok;
  assign rem_ok    = accept & (cmd == CMD_REMOVE) & idx_ok;

  // cell chain
  assign prefix[0] = 1'b1;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0]    lk, rk;
    logic [HANDLE_W-1:0] lh, rh;

    assign ctl[i].desc      = desc_r;
    assign ctl[i].occupied  = count_r > CW'(i);
    assign ctl[i].ins_en    = add_ok;
    assign ctl[i].rem_shift = rem_ok & (idx_x <= XW'(i));

    if (i == 0) begin : g_first
      assign lk = in_key;
      assign lh = in_handle;
    end else begin : g_left
      assign lk = cell_key[i-1];
      assign lh = cell_handle[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rk = cell_key[i];
      assign rh = cell_handle[i];
    end else begin : g_right
      assign rk = cell_key[i+1];
      assign rh = cell_handle[i+1];
    end

    sil_cell u_cell (
      .clk          (clk),
      .ctl          (ctl[i]),
      .new_key      (in_key),
      .new_handle   (in_handle),
      .left_key     (lk),
      .left_handle  (lh),
      .right_key    (rk),
      .right_handle (rh),
      .prefix_in    (prefix[i]),
      .prefix_out   (prefix[i+1]),
      .ins_here     (ins_here[i]),
      .key          (cell_key[i]),
      .handle       (cell_handle[i])
    );
  end

  // encode the one-hot insert point
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      ins_pos = ins_pos | (ins_here[i] ? IW'(i) : '0);
    end
  end
  assign ins_pos_x = XW'(ins_pos);

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (add_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count_nxt_x = LW'(count_nxt);

  // result of the accepted transaction
  always_comb begin
    res          = '0;
    res.count    = count_nxt_x[COUNT_W-1:0];
    res.status   = ST_OK;
    case (cmd) inside
      CMD_ADD: begin
        if (list_full) begin
          res.status = ST_FULL;
        end else begin
          res.position = ins_pos_x[POS_W-1:0];
        end
      end
      CMD_GET, CMD_REMOVE: begin
        res.position = in_index;
        if (!idx_ok) begin
          res.status = ST_RANGE;
        end else if (get_ok) begin
          res.key    = cell_key[rd_sel];
          res.handle = cell_handle[rd_sel];
        end
      end
      default: ;
    endcase
  end

  sil_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .res_in    (res),
    .out_stall (out_stall),
    .full      (full_buf),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign out_position   = res_q.position;
  assign out_key_out    = res_q.key;
  assign out_handle_out = res_q.handle;
  assign out_count_out  = res_q.count;
  assign out_status     = res_q.status;

  // checks
  `SIL_ASSERT_IMPL(a_count_bound, 1'b1, LW'(count_r) <= LW'(CAPACITY), "count beyond capacity")
  `SIL_ASSERT_IMPL(a_one_insert, add_ok, $onehot(ins_here), "insert point not unique")
  `SIL_ASSERT_IMPL(a_room_left, add_ok, !prefix[CAPACITY], "no free cell for insert")
  `SIL_ASSERT_NEXT(a_add_count, add_ok, count_r == CW'($past(count_r) + CW'(1)),
                   "add did not count")
  `SIL_ASSERT_NEXT(a_full_hold, accept && cmd == CMD_ADD && list_full,
                   $stable(count_r), "full add changed count")

endmodule
